/* hdl/ondemand_readahead_window_defines.svh */
// Assertion macros used by the readahead window top level.
`ifndef ONDEMAND_READAHEAD_WINDOW_DEFINES_SVH
`define ONDEMAND_READAHEAD_WINDOW_DEFINES_SVH
`ifndef SYNTHESIS
`define ORW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ORW_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ORW_ASSERT(lbl, clk, rst_n, prop, msg)
`define ORW_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* hdl/orw_pkg.sv */
// Types and constants shared by the readahead window modules.
`timescale 1ns / 1ps
package orw_pkg;

  localparam int unsigned PaddrWidth = 4;
  localparam int unsigned InDataWidth = 136;
  localparam int unsigned OutDataWidth = 72;

  localparam logic [1:0] RegMaxWindow = 2'd0;
  localparam logic [1:0] RegInitialCap = 2'd1;
  localparam logic [1:0] RegLegacyMiss = 2'd2;

  localparam logic [15:0] MaxWindowReset = 16'd32;
  localparam logic [15:0] InitialCapReset = 16'd32;
  localparam logic LegacyMissReset = 1'b0;

  typedef struct packed {
    logic [15:0] max_window_pages;
    logic [15:0] initial_cap_pages;
    logic        legacy_miss_mode;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        page_offset;
    logic [15:0]        request_pages;
    logic               marker_hit;
    logic signed [32:0] previous_position;
    logic [31:0]        next_hole_page;
    logic [15:0]        backward_run;
  } in_item_t;

  typedef struct packed {
    logic        read_issued;
    logic [31:0] read_start;
    logic [16:0] read_pages;
    logic [16:0] async_pages;
  } out_item_t;

endpackage

/* hdl/ondemand_readahead_window.sv */
// Top level of the on-demand readahead window controller.
// Usage:
//   The slave stream carries one page-cache event per transfer: the access
//   page, the request size, the previous byte position and two cache query
//   answers in tdata, and the marker-hit flag in tuser. The master stream
//   returns exactly one decision per event: start, size and async tail of
//   the read in tdata, and the read-issued flag in tuser.
//   An event is registered in the input register on acceptance, and its
//   decision is registered into the output register once that is free.
//   One event per cycle is sustained while the receiver takes every result;
//   the limit is the single decision pass that reads and updates the window
//   registers in the same cycle. The APB-style port writes the three
//   configuration registers at byte addresses 0, 4 and 8; the user must
//   write it only while no event is in flight, as the block does not check.
//   Reset clears the window to zero and loads the register defaults.
//   When the receiver stalls, the pending result holds and one more event is
//   still accepted into the input register; then tready drops until the
//   result transfer completes.
`timescale 1ns / 1ps
`include "ondemand_readahead_window_defines.svh"
module ondemand_readahead_window
  import orw_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // page_offset, request_pages, previous_position, next_hole_page, backward_run, zero pad
  input  logic [InDataWidth-1:0]  s_axis_tdata_i,
  // marker_hit
  input  logic                    s_axis_tuser_i,
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // read_start, read_pages, async_pages, zero pad
  output logic [OutDataWidth-1:0] m_axis_tdata_o,
  // read_issued
  output logic                    m_axis_tuser_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PaddrWidth-1:0]   paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t      cfg;
  in_item_t  in_item;
  in_item_t  in_item_q;
  out_item_t res;
  out_item_t out_q;
  logic      in_valid_q;
  logic      out_valid_q;
  logic      in_accept;
  logic      advance;

  orw_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  assign in_item.page_offset = s_axis_tdata_i[31:0];
  assign in_item.request_pages = s_axis_tdata_i[47:32];
  assign in_item.marker_hit = s_axis_tuser_i;
  assign in_item.previous_position = $signed(s_axis_tdata_i[80:48]);
  assign in_item.next_hole_page = s_axis_tdata_i[112:81];
  assign in_item.backward_run = s_axis_tdata_i[128:113];

  assign advance = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_item;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  orw_core #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .fire_i(advance),
    .item_i(in_item_q),
    .res_o (res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o = out_q.read_issued;
  assign m_axis_tdata_o = {6'd0, out_q.async_pages, out_q.read_pages, out_q.read_start};

  `ORW_ASSERT(a_held_event, clk_i, rst_ni, in_valid_q && !advance |=> in_valid_q, "event lost while stalled")
  `ORW_ASSERT_NEVER(a_ready_low, clk_i, rst_ni, !s_axis_tready_o && !(in_valid_q && out_valid_q), "tready low without both stages full")
  `ORW_ASSERT(a_noread_zero, clk_i, rst_ni, out_valid_q && !out_q.read_issued |-> (out_q.read_start == 32'd0) && (out_q.read_pages == 17'd0) && (out_q.async_pages == 17'd0), "no-read result carries data")
  `ORW_ASSERT_NEVER(a_async_range, clk_i, rst_ni, out_valid_q && (out_q.async_pages > out_q.read_pages), "async tail exceeds read size")

endmodule

/* hdl/orw_cfg.sv */
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module orw_cfg
  import orw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [15:0] max_window_q, max_window_d;
  logic [15:0] initial_cap_q, initial_cap_d;
  logic        legacy_miss_q, legacy_miss_d;
  logic        wr_en;
  logic [1:0]  reg_index;

  assign pready = 1'b1;
  assign reg_index = paddr[3:2];
  assign wr_en = psel && penable && pwrite && pready;

  always_comb begin
    max_window_d = max_window_q;
    initial_cap_d = initial_cap_q;
    legacy_miss_d = legacy_miss_q;
    if (wr_en) begin
      case (reg_index)
        RegMaxWindow: max_window_d = pwdata[15:0];
        RegInitialCap: initial_cap_d = pwdata[15:0];
        RegLegacyMiss: legacy_miss_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_window_q <= MaxWindowReset;
      initial_cap_q <= InitialCapReset;
      legacy_miss_q <= LegacyMissReset;
    end else begin
      max_window_q <= max_window_d;
      initial_cap_q <= initial_cap_d;
      legacy_miss_q <= legacy_miss_d;
    end
  end

  always_comb begin
    case (reg_index)
      RegMaxWindow: prdata = {16'd0, max_window_q};
      RegInitialCap: prdata = {16'd0, initial_cap_q};
      RegLegacyMiss: prdata = {31'd0, legacy_miss_q};
      default: prdata = 32'd0;
    endcase
  end

  assign cfg_o.max_window_pages = max_window_q;
  assign cfg_o.initial_cap_pages = initial_cap_q;
  assign cfg_o.legacy_miss_mode = legacy_miss_q;

endmodule

/* hdl/orw_core.sv */
// Readahead decision logic and the window state registers.
`timescale 1ns / 1ps
module orw_core
  import orw_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      fire_i,
  input  in_item_t  item_i,
  output out_item_t res_o
);

  localparam int unsigned PageShift = $clog2(PAGE_BYTES);

  typedef enum logic [1:0] {
    DecNoRead = 2'd0,
    DecRandom = 2'd1,
    DecWindow = 2'd2
  } decision_e;

  function automatic logic [18:0] pow2_up(input logic [17:0] v);
    logic [18:0] m;
    m = {1'b0, v} - 19'd1;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    if (v == 18'd0) begin
      return 19'd0;
    end
    return m + 19'd1;
  endfunction

  function automatic logic [15:0] initial_size(input logic [18:0] n, input logic [15:0] cap);
    logic [18:0] cap_wide;
    cap_wide = {3'b000, cap};
    if (n <= (cap_wide >> 5)) begin
      return 16'({n, 2'b00});
    end else if (n <= (cap_wide >> 2)) begin
      return 16'({n, 1'b0});
    end
    return cap;
  endfunction

  function automatic logic [15:0] next_size(input logic [16:0] cur, input logic [15:0] cap);
    logic [18:0] cap_wide;
    logic [18:0] n;
    cap_wide = {3'b000, cap};
    n = ({2'b00, cur} < (cap_wide >> 4)) ? {cur, 2'b00} : {1'b0, cur, 1'b0};
    return (n < cap_wide) ? n[15:0] : cap;
  endfunction

  logic [31:0] win_start_q, win_start_d;
  logic [16:0] win_size_q, win_size_d;
  logic [16:0] win_async_q, win_async_d;

  logic [31:0]        off;
  logic [15:0]        req;
  logic [15:0]        mx;
  logic [31:0]        end_b;
  logic [31:0]        end_a;
  logic [31:0]        hole_dist;
  logic               hole_ok;
  logic [16:0]        hit_want;
  logic               neg_pos;
  logic signed [34:0] pos_adj;
  logic signed [34:0] prev_page_s;
  logic signed [34:0] page_diff_s;
  logic               seq_legacy;
  logic [31:0]        prev_page_u;
  logic [31:0]        page_diff_u;
  logic               seq_fixed;
  logic               seq_miss;
  logic [16:0]        back_scaled;
  logic [17:0]        ctx_want;
  logic [15:0]        init_size;
  logic [16:0]        init_async;
  logic [15:0]        ramp_size;
  decision_e          decision;
  logic [31:0]        start_p;
  logic [16:0]        size_p;
  logic [16:0]        async_p;
  logic               grow;
  logic [15:0]        grow_async;
  logic [16:0]        fin_size;
  logic [16:0]        fin_async;

  assign off = item_i.page_offset;
  assign req = item_i.request_pages;
  assign mx = cfg_i.max_window_pages;

  assign end_b = win_start_q + {15'd0, win_size_q};
  assign end_a = end_b - {15'd0, win_async_q};

  assign hole_dist = item_i.next_hole_page - off;
  assign hole_ok = (item_i.next_hole_page != 32'd0) && (hole_dist <= {16'd0, mx});
  assign hit_want = hole_dist[16:0] + {1'b0, req};

  // Legacy test divides the signed byte position with truncation toward zero.
  assign neg_pos = item_i.previous_position[32];
  assign pos_adj = 35'(item_i.previous_position)
                   + (neg_pos ? 35'(PAGE_BYTES - 1) : 35'sd0);
  assign prev_page_s = pos_adj >>> PageShift;
  assign page_diff_s = $signed({3'b000, off}) - prev_page_s;
  assign seq_legacy = (page_diff_s <= 35'sd1);

  assign prev_page_u = item_i.previous_position[31:0] >> PageShift;
  assign page_diff_u = off - prev_page_u;
  assign seq_fixed = (page_diff_u <= 32'd1);

  assign seq_miss = cfg_i.legacy_miss_mode ? seq_legacy : seq_fixed;

  assign back_scaled = ({16'd0, item_i.backward_run} >= off) ?
                       {item_i.backward_run, 1'b0} : {1'b0, item_i.backward_run};
  assign ctx_want = {1'b0, back_scaled} + {2'b00, req};

  assign init_size = initial_size(pow2_up({2'b00, req}), cfg_i.initial_cap_pages);
  assign init_async = (init_size > req) ? {1'b0, init_size - req} : {1'b0, init_size};
  assign ramp_size = next_size(win_size_q, mx);

  always_comb begin
    decision = DecWindow;
    start_p = off;
    size_p = {1'b0, init_size};
    async_p = init_async;
    if (off == 32'd0) begin
      decision = DecWindow;
    end else if ((off == end_a) || (off == end_b)) begin
      start_p = end_b;
      size_p = {1'b0, ramp_size};
      async_p = {1'b0, ramp_size};
    end else if (item_i.marker_hit) begin
      if (!hole_ok) begin
        decision = DecNoRead;
      end else begin
        start_p = item_i.next_hole_page;
        size_p = {1'b0, next_size(hit_want, mx)};
        async_p = size_p;
      end
    end else if (req > mx) begin
      decision = DecWindow;
    end else if (seq_miss) begin
      decision = DecWindow;
    end else if (item_i.backward_run != 16'd0) begin
      size_p = {1'b0, initial_size(pow2_up(ctx_want), mx)};
      async_p = size_p;
    end else begin
      decision = DecRandom;
    end
  end

  // A read that starts at the access itself and is all async tail gets a further tail appended at once.
  assign grow = (off == start_p) && (size_p == async_p);
  assign grow_async = next_size(size_p, mx);
  assign fin_size = grow ? (size_p + {1'b0, grow_async}) : size_p;
  assign fin_async = grow ? {1'b0, grow_async} : async_p;

  always_comb begin
    win_start_d = win_start_q;
    win_size_d = win_size_q;
    win_async_d = win_async_q;
    res_o = '0;
    case (decision)
      DecWindow: begin
        res_o.read_issued = 1'b1;
        res_o.read_start = start_p;
        res_o.read_pages = fin_size;
        res_o.async_pages = fin_async;
        if (fire_i) begin
          win_start_d = start_p;
          win_size_d = fin_size;
          win_async_d = fin_async;
        end
      end
      DecRandom: begin
        res_o.read_issued = 1'b1;
        res_o.read_start = off;
        res_o.read_pages = {1'b0, req};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= 32'd0;
      win_size_q <= 17'd0;
      win_async_q <= 17'd0;
    end else begin
      win_start_q <= win_start_d;
      win_size_q <= win_size_d;
      win_async_q <= win_async_d;
    end
  end

endmodule

/* sim/readahead_decision_checker.sv */
// Checker that predicts and compares every readahead decision of the window controller.
`timescale 1ns / 1ps
module readahead_decision_checker
  import orw_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    ev_valid_i,
  input  logic                    ev_ready_i,
  input  logic [InDataWidth-1:0]  ev_data_i,
  input  logic                    ev_flag_i,
  input  logic                    dec_valid_i,
  input  logic                    dec_ready_i,
  input  logic [OutDataWidth-1:0] dec_data_i,
  input  logic                    dec_flag_i,
  input  logic                    psel_i,
  input  logic                    penable_i,
  input  logic                    pwrite_i,
  input  logic [PaddrWidth-1:0]   paddr_i,
  input  logic [31:0]             pwdata_i,
  input  logic                    pready_i,
  output int unsigned             mismatches_o
);

  localparam int unsigned WindowMask = 32'h1_FFFF;

  int unsigned max_win;
  int unsigned init_cap;
  bit          legacy_miss;
  int unsigned win_start;
  int unsigned win_len;
  int unsigned win_tail;

  out_item_t   expected_decisions[$];
  int unsigned mismatch_count = 0;
  in_item_t    ev;
  out_item_t   predicted;
  out_item_t   want;

  assign mismatches_o = mismatch_count;

  function automatic int unsigned round_pow2(int unsigned v);
    int unsigned p;
    p = 1;
    if (v == 0) return 0;
    while (p < v && p < 32'h8000_0000) p = p << 1;
    return p;
  endfunction

  function automatic int unsigned first_window(int unsigned want_len, int unsigned cap);
    int unsigned n;
    n = round_pow2(want_len);
    if (n <= cap / 32) return n * 4;
    if (n <= cap / 4) return n * 2;
    return cap;
  endfunction

  function automatic int unsigned ramp_window(int unsigned cur, int unsigned cap);
    int unsigned n;
    n = (cur < cap / 16) ? 4 * cur : 2 * cur;
    return (n < cap) ? n : cap;
  endfunction

  task automatic decide_readahead(input in_item_t e, output out_item_t res);
    int unsigned off;
    int unsigned req;
    int unsigned hole;
    int unsigned back;
    int unsigned len;
    int unsigned prev_pg;
    int unsigned gap;
    longint      prev_full;
    longint      prev_page;
    bit          restart;
    bit          no_read;
    bit          random_read;
    bit          seq;
    off = e.page_offset;
    req = e.request_pages;
    hole = e.next_hole_page;
    back = e.backward_run;
    restart = 1'b0;
    no_read = 1'b0;
    random_read = 1'b0;
    res = '0;

    if (off == 0) begin
      restart = 1'b1;
    end else if (off == win_start + win_len - win_tail || off == win_start + win_len) begin
      len = ramp_window(win_len, max_win);
      win_start = win_start + win_len;
      win_len = len & WindowMask;
      win_tail = win_len;
    end else if (e.marker_hit) begin
      if (hole == 0 || hole - off > max_win) begin
        no_read = 1'b1;
      end else begin
        len = (hole - off) + req;
        win_start = hole;
        win_len = ramp_window(len & WindowMask, max_win) & WindowMask;
        win_tail = win_len;
      end
    end else if (req > max_win) begin
      restart = 1'b1;
    end else begin
      if (legacy_miss) begin
        prev_full = {{31{e.previous_position[32]}}, e.previous_position};
        prev_page = prev_full / longint'(PAGE_BYTES);
        seq = (longint'({32'd0, off}) - prev_page) <= 1;
      end else begin
        prev_pg = e.previous_position[31:0] / PAGE_BYTES;
        gap = off - prev_pg;
        seq = gap <= 1;
      end
      if (seq) begin
        restart = 1'b1;
      end else if (back != 0) begin
        len = back;
        if (len >= off) len = len * 2;
        win_start = off;
        win_len = first_window(len + req, max_win) & WindowMask;
        win_tail = win_len;
      end else begin
        random_read = 1'b1;
      end
    end

    if (restart) begin
      win_start = off;
      win_len = first_window(req, init_cap) & WindowMask;
      win_tail = (win_len > req) ? win_len - req : win_len;
    end

    if (random_read) begin
      res.read_issued = 1'b1;
      res.read_start = off;
      res.read_pages = 17'(req);
    end else if (!no_read) begin
      if (off == win_start && win_len == win_tail) begin
        win_tail = ramp_window(win_len, max_win) & WindowMask;
        win_len = (win_len + win_tail) & WindowMask;
      end
      res.read_issued = 1'b1;
      res.read_start = win_start;
      res.read_pages = win_len[16:0];
      res.async_pages = win_tail[16:0];
    end
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp_val);
    $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got, exp_val);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_win = MaxWindowReset;
      init_cap = InitialCapReset;
      legacy_miss = LegacyMissReset;
      win_start = 0;
      win_len = 0;
      win_tail = 0;
      expected_decisions.delete();
    end else begin
      if (dec_valid_i && dec_ready_i) begin
        if (expected_decisions.size() == 0) begin
          report_mismatch("unexpected decision transfer", dec_data_i[31:0], '0);
        end else begin
          want = expected_decisions.pop_front();
          if (dec_flag_i !== want.read_issued)
            report_mismatch("read_issued", 32'(dec_flag_i), 32'(want.read_issued));
          if (dec_data_i[31:0] !== want.read_start)
            report_mismatch("read_start", dec_data_i[31:0], want.read_start);
          if (dec_data_i[48:32] !== want.read_pages)
            report_mismatch("read_pages", 32'(dec_data_i[48:32]), 32'(want.read_pages));
          if (dec_data_i[65:49] !== want.async_pages)
            report_mismatch("async_pages", 32'(dec_data_i[65:49]), 32'(want.async_pages));
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[PaddrWidth-1:2])
          RegMaxWindow: max_win = pwdata_i[15:0];
          RegInitialCap: init_cap = pwdata_i[15:0];
          RegLegacyMiss: legacy_miss = pwdata_i[0];
          default: ;
        endcase
      end
      if (ev_valid_i && ev_ready_i) begin
        ev.page_offset = ev_data_i[31:0];
        ev.request_pages = ev_data_i[47:32];
        ev.previous_position = ev_data_i[80:48];
        ev.next_hole_page = ev_data_i[112:81];
        ev.backward_run = ev_data_i[128:113];
        ev.marker_hit = ev_flag_i;
        decide_readahead(ev, predicted);
        expected_decisions.push_back(predicted);
      end
    end
  end

endmodule

/* sim/tb_ondemand_readahead_window.sv */
// Testbench top that drives page-cache events and register writes into the readahead controller.
`timescale 1ns / 1ps
module tb_ondemand_readahead_window;
  import orw_pkg::*;

  localparam int unsigned PageBytes = 4096;
  localparam int unsigned NumPhases = 9;
  localparam int unsigned EventsPerPhase = 145;
  localparam int unsigned WatchdogLimit = 1000;
  localparam logic [32:0] PrevNone = 33'h1_FFFF_FFFF;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [InDataWidth-1:0]  s_tdata;
  logic                    s_tuser;
  logic                    m_tvalid;
  logic                    m_tready;
  logic [OutDataWidth-1:0] m_tdata;
  logic                    m_tuser;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [PaddrWidth-1:0]   paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;

  int unsigned mismatches;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cfg_max;
  int unsigned events_sent;
  int unsigned decisions_seen;
  int unsigned no_read_seen;
  int unsigned settings_used;
  int unsigned quiet_cycles;
  logic [31:0] seen_start;
  logic [16:0] seen_pages;
  logic [16:0] seen_async;
  logic [31:0] prior_off;
  logic [15:0] prior_req;

  ondemand_readahead_window #(
    .PAGE_BYTES(PageBytes)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  readahead_decision_checker #(
    .PAGE_BYTES(PageBytes)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_valid_i  (s_tvalid),
    .ev_ready_i  (s_tready),
    .ev_data_i   (s_tdata),
    .ev_flag_i   (s_tuser),
    .dec_valid_i (m_tvalid),
    .dec_ready_i (m_tready),
    .dec_data_i  (m_tdata),
    .dec_flag_i  (m_tuser),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pready_i    (pready),
    .mismatches_o(mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (s_tvalid && s_tready) events_sent <= events_sent + 1;
    if (m_tvalid && m_tready) begin
      decisions_seen <= decisions_seen + 1;
      if (!m_tuser) no_read_seen <= no_read_seen + 1;
      seen_start <= m_tdata[31:0];
      seen_pages <= m_tdata[48:32];
      seen_async <= m_tdata[65:49];
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Timeout: no transfer for %0d cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t mk_event(logic [31:0] off, logic [15:0] req, logic hit,
                                        logic [32:0] prev, logic [31:0] hole,
                                        logic [15:0] back);
    in_item_t e;
    e.page_offset = off;
    e.request_pages = req;
    e.marker_hit = hit;
    e.previous_position = prev;
    e.next_hole_page = hole;
    e.backward_run = back;
    return e;
  endfunction

  function automatic logic [32:0] byte_pos(logic [31:0] page);
    return {1'b0, page[19:0], 12'($urandom_range(PageBytes - 1))};
  endfunction

  task automatic send_event(input in_item_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata = {7'd0, e.backward_run, e.next_hole_page, e.previous_position,
               e.request_pages, e.page_offset};
    s_tuser = e.marker_hit;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
    prior_off = e.page_offset;
    prior_req = e.request_pages;
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (events_sent != decisions_seen) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic apply_settings(input int unsigned max_pages, input int unsigned cap_pages,
                                input bit legacy);
    wait_drained();
    write_register(RegMaxWindow, max_pages);
    write_register(RegInitialCap, cap_pages);
    write_register(RegLegacyMiss, 32'(legacy));
    cfg_max = max_pages;
    settings_used++;
  endtask

  task automatic send_aimed(input bit at_marker, input logic [15:0] req, input logic hit);
    logic [31:0] off;
    wait_drained();
    off = seen_start + 32'(seen_pages);
    if (at_marker) off = off - 32'(seen_async);
    send_event(mk_event(off, req, hit, PrevNone, off + 32'd5, 16'd0));
  endtask

  task automatic run_directed();
    send_event(mk_event(32'd0, 16'd0, 1'b0, PrevNone, 32'd0, 16'd0));
    send_event(mk_event(32'd0, 16'd4, 1'b0, PrevNone, 32'd0, 16'd0));
    send_aimed(1'b1, 16'd4, 1'b1);
    send_aimed(1'b1, 16'd16, 1'b1);
    send_aimed(1'b0, 16'd8, 1'b0);
    send_aimed(1'b0, 16'd2, 1'b1);
    send_event(mk_event(32'd5000, 16'd7, 1'b0, 33'd0, 32'd0, 16'd0));
    send_event(mk_event(32'd9000, 16'd0, 1'b0, 33'd0, 32'd0, 16'd0));
    send_event(mk_event(32'd123456, 16'd8, 1'b1, 33'd0, 32'd0, 16'd0));
    send_event(mk_event(32'd200000, 16'd8, 1'b1, 33'd0, 32'd200033, 16'd0));
    send_event(mk_event(32'd300000, 16'd3, 1'b1, 33'd0, 32'd300032, 16'd0));
    send_event(mk_event(32'hFFFF_FFF0, 16'hFFFF, 1'b1, PrevNone, 32'hFFFF_FFFF, 16'hFFFF));
    send_event(mk_event(32'd77, 16'hFFFF, 1'b0, 33'd0, 32'd0, 16'd0));
    send_event(mk_event(32'd400001, 16'd8, 1'b0, byte_pos(32'd400000), 32'd0, 16'd0));
    send_event(mk_event(32'd400001, 16'd2, 1'b0, byte_pos(32'd400001), 32'd0, 16'd0));
    send_event(mk_event(32'h0010_0000, 16'd1, 1'b0, PrevNone, 32'd0, 16'd0));
    send_event(mk_event(32'd600000, 16'd8, 1'b0, 33'd0, 32'd0, 16'd100));
    send_event(mk_event(32'd50, 16'd0, 1'b0, 33'd0, 32'd0, 16'hFFFF));
    send_event(mk_event(32'hFFFF_FFFF, 16'd1, 1'b0, PrevNone, 32'hFFFF_FFFF, 16'hFFFF));
    send_event(mk_event(32'h000F_FFFF, 16'd16, 1'b0, {1'b0, 32'hFFFF_FFFF}, 32'd0, 16'd0));
    send_event(mk_event(32'd0, 16'hFFFF, 1'b1, PrevNone, 32'd0, 16'd0));
    // The signed miss test differs from the unsigned one around negative and wrapped pages.
    apply_settings(32, 32, 1'b1);
    send_event(mk_event(32'd1, 16'd4, 1'b0, PrevNone, 32'd0, 16'd0));
    send_event(mk_event(32'h0010_0000, 16'd4, 1'b0, PrevNone, 32'd0, 16'd0));
    send_event(mk_event(32'h000F_FFFF, 16'd4, 1'b0, {1'b0, 32'hFFFF_FFFF}, 32'd0, 16'd0));
    send_event(mk_event(32'd10, 16'd4, 1'b0, {1'b0, 32'h0000_B000}, 32'd0, 16'd0));
  endtask

  task automatic send_random_event();
    int unsigned pick;
    int unsigned step;
    logic [31:0] off;
    logic [31:0] hole;
    logic [15:0] req;
    logic [15:0] back;
    logic [32:0] prev;
    logic        hit;
    pick = $urandom_range(99);
    req = ($urandom_range(7) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(48));
    hit = 1'b0;
    back = 16'd0;
    prev = ($urandom_range(7) == 0) ? PrevNone : {1'b0, 32'($urandom)};
    if (pick < 60) begin
      // Reader-like sequences, mostly aimed at the window that the block last reported.
      if ($urandom_range(3) != 0) wait_drained();
      step = $urandom_range(9);
      off = seen_start + 32'(seen_pages);
      case (step)
        0, 1, 2, 3: begin
          off = off - 32'(seen_async);
          hit = 1'b1;
        end
        4, 5: hit = 1'(($urandom_range(3) == 0));
        6: begin
          off = prior_off + 32'(prior_req);
          prev = byte_pos(off - 32'($urandom_range(1)));
        end
        7: begin
          off = seen_start + 32'($urandom_range(1, 2 * seen_pages + 2));
          hit = 1'b1;
        end
        8: begin
          off = ($urandom_range(3) == 0) ? 32'($urandom_range(1, 600)) :
                                           32'($urandom_range(1, 1 << 20));
          back = 16'($urandom_range(1, 512));
        end
        default: off = 32'd0;
      endcase
      hole = ($urandom_range(5) == 0) ? 32'd0 : off + 32'($urandom_range(1, cfg_max + 8));
    end else if (pick < 80) begin
      off = $urandom;
      req = 16'($urandom_range(cfg_max > 65535 ? 65535 : cfg_max));
      hole = $urandom;
    end else begin
      off = $urandom;
      req = 16'($urandom_range(65535));
      hit = 1'($urandom_range(1));
      hole = ($urandom_range(7) == 0) ? 32'd0 : 32'($urandom);
      back = 16'($urandom_range(65535));
    end
    send_event(mk_event(off, req, hit, prev, hole, back));
  endtask

  initial begin
    rst_ni = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    events_sent = 0;
    decisions_seen = 0;
    no_read_seen = 0;
    settings_used = 1;
    quiet_cycles = 0;
    seen_start = '0;
    seen_pages = '0;
    seen_async = '0;
    prior_off = '0;
    prior_req = '0;
    cfg_max = MaxWindowReset;
    send_idle_pct = 24;
    recv_idle_pct = 52;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();

    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 24;
        recv_idle_pct = 52;
      end else if (phase < 6) begin
        send_idle_pct = 52;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: apply_settings(32, 32, 1'b0);
        1: apply_settings(1, 1, 1'b1);
        2: apply_settings(32768, 32768, 1'b0);
        3: apply_settings(0, 65535, 1'b1);
        4: apply_settings(65535, 0, 1'b0);
        5: apply_settings(128, 64, 1'b1);
        6: apply_settings(16, 512, 1'b0);
        default: apply_settings($urandom_range(1, 32768), $urandom_range(1, 32768),
                                1'($urandom_range(1)));
      endcase
      for (int n = 0; n < EventsPerPhase; n++) begin
        if (n == 70) wait_drained();
        send_random_event();
      end
    end

    wait_drained();
    repeat (10) @(negedge clk_i);
    $display("Covered %0d page-cache events under %0d register settings.",
             events_sent, settings_used);
    $display("Checked %0d decisions, %0d of them without a read.",
             decisions_seen, no_read_seen);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
